/* rtl/core/chunked_transfer_decoder_defines.svh */
// ---------------------------------------------------------------------------
// chunked_transfer_decoder_defines
// Assertion macros for the chunked transfer decoder RTL.
// ---------------------------------------------------------------------------
`ifndef CHUNKED_TRANSFER_DECODER_DEFINES_SVH
`define CHUNKED_TRANSFER_DECODER_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define CTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define CTD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/core/ctd_pkg.sv */
// ---------------------------------------------------------------------------
// ctd_pkg
// Types and constants shared by the chunked transfer decoder modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctd_pkg;

  localparam int unsigned LEN_BITS = 32;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_VT   = 8'h0B;
  localparam logic [7:0] CH_FF   = 8'h0C;

  typedef enum logic [3:0] {
    PH_BLANK = 4'd0,
    PH_DIGIT = 4'd1,
    PH_TAIL  = 4'd2,
    PH_EXT   = 4'd3,
    PH_LF    = 4'd4,
    PH_DATA  = 4'd5,
    PH_TCR   = 4'd6,
    PH_TLF   = 4'd7,
    PH_ERR   = 4'd8
  } phase_e;

  typedef struct packed {
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       blank;
    logic       cr;
    logic       lf;
    logic       semi;
  } byte_class_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       chunk_done;
    logic       bad_request;
    logic [3:0] phase_now;
  } result_t;

endpackage

/* rtl/core/ctd_byte_class.sv */
// ---------------------------------------------------------------------------
// ctd_byte_class
// Classifies one input byte: hex digit and its value, blank, CR, LF, ';'.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctd_byte_class (
  input  logic [7:0]           byte_i,
  output ctd_pkg::byte_class_t class_o
);

  logic [7:0] dig_off;
  logic [7:0] up_off;
  logic [7:0] lo_off;

  assign dig_off = byte_i - 8'h30;
  assign up_off  = byte_i - 8'h37;
  assign lo_off  = byte_i - 8'h57;

  always_comb begin
    class_o = '0;
    if (byte_i >= 8'h30 && byte_i <= 8'h39) begin
      class_o.hex_ok  = 1'b1;
      class_o.hex_val = dig_off[3:0];
    end else if (byte_i >= 8'h41 && byte_i <= 8'h46) begin
      class_o.hex_ok  = 1'b1;
      class_o.hex_val = up_off[3:0];
    end else if (byte_i >= 8'h61 && byte_i <= 8'h66) begin
      class_o.hex_ok  = 1'b1;
      class_o.hex_val = lo_off[3:0];
    end
    class_o.blank = (byte_i == ctd_pkg::CH_SP) || (byte_i == ctd_pkg::CH_TAB) ||
                    (byte_i == ctd_pkg::CH_VT) || (byte_i == ctd_pkg::CH_FF);
    class_o.cr    = (byte_i == ctd_pkg::CH_CR);
    class_o.lf    = (byte_i == ctd_pkg::CH_LF);
    class_o.semi  = (byte_i == ctd_pkg::CH_SEMI);
  end

endmodule

/* rtl/core/ctd_core.sv */
// ---------------------------------------------------------------------------
// ctd_core
// Framing state machine with size and remaining-byte counters; steps once
// per transfer and produces that transfer's result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "chunked_transfer_decoder_defines.svh"

module ctd_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  input  ctd_pkg::byte_class_t class_i,
  output ctd_pkg::result_t     result_o
);

  localparam int unsigned LB = ctd_pkg::LEN_BITS;

  ctd_pkg::phase_e phase_q, phase_d;
  logic [LB-1:0]   size_q, size_d;
  logic [LB-1:0]   rem_q, rem_d;
  logic            seen_q, seen_d;

  logic            ovf;
  logic [LB-1:0]   size_shift;
  logic [LB-1:0]   rem_dec;
  logic            valid;
  logic            done;

  assign ovf        = |size_q[LB-1 -: 4];
  assign size_shift = {size_q[LB-5:0], class_i.hex_val};
  assign rem_dec    = (rem_q != '0) ? rem_q - LB'(1) : rem_q;

  // Next state and counters.
  always_comb begin
    phase_d = phase_q;
    size_d  = size_q;
    rem_d   = rem_q;
    seen_d  = seen_q;
    case (phase_q)
      ctd_pkg::PH_BLANK: begin
        if (!class_i.blank) begin
          if (class_i.hex_ok && !ovf) begin
            size_d  = size_shift;
            seen_d  = 1'b1;
            phase_d = ctd_pkg::PH_DIGIT;
          end else begin
            phase_d = ctd_pkg::PH_ERR;
          end
        end
      end
      ctd_pkg::PH_DIGIT: begin
        if (class_i.hex_ok) begin
          if (ovf) begin
            phase_d = ctd_pkg::PH_ERR;
          end else begin
            size_d = size_shift;
            seen_d = 1'b1;
          end
        end else if (class_i.semi) begin
          phase_d = ctd_pkg::PH_EXT;
        end else if (class_i.cr) begin
          phase_d = ctd_pkg::PH_LF;
        end else begin
          phase_d = ctd_pkg::PH_TAIL;
        end
      end
      ctd_pkg::PH_TAIL: begin
        if (class_i.semi) begin
          phase_d = ctd_pkg::PH_EXT;
        end else if (class_i.cr) begin
          phase_d = ctd_pkg::PH_LF;
        end
      end
      ctd_pkg::PH_EXT: begin
        if (class_i.cr) begin
          phase_d = ctd_pkg::PH_LF;
        end
      end
      ctd_pkg::PH_LF: begin
        if (!class_i.lf || !seen_q) begin
          phase_d = ctd_pkg::PH_ERR;
        end else begin
          rem_d   = size_q;
          phase_d = (size_q == '0) ? ctd_pkg::PH_TCR : ctd_pkg::PH_DATA;
        end
      end
      ctd_pkg::PH_DATA: begin
        rem_d = rem_dec;
        if (rem_dec == '0) begin
          phase_d = ctd_pkg::PH_TCR;
        end
      end
      ctd_pkg::PH_TCR: begin
        phase_d = class_i.cr ? ctd_pkg::PH_TLF : ctd_pkg::PH_ERR;
      end
      ctd_pkg::PH_TLF: begin
        if (class_i.lf) begin
          phase_d = ctd_pkg::PH_BLANK;
          size_d  = '0;
          rem_d   = '0;
          seen_d  = 1'b0;
        end else begin
          phase_d = ctd_pkg::PH_ERR;
        end
      end
      default: begin
        phase_d = ctd_pkg::PH_ERR;
      end
    endcase
  end

  // Result of this transfer.
  always_comb begin
    valid = (phase_q == ctd_pkg::PH_DATA);
    done  = (phase_q == ctd_pkg::PH_TLF) && class_i.lf;
    result_o.payload_byte  = valid ? byte_i : 8'h00;
    result_o.payload_valid = valid;
    result_o.chunk_done    = done;
    result_o.bad_request   = (phase_d == ctd_pkg::PH_ERR);
    result_o.phase_now     = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ctd_pkg::PH_BLANK;
      size_q  <= '0;
      rem_q   <= '0;
      seen_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      size_q  <= size_d;
      rem_q   <= rem_d;
      seen_q  <= seen_d;
    end
  end

  `CTD_ASSERT(a_err_sticky, phase_q == ctd_pkg::PH_ERR |=> phase_q == ctd_pkg::PH_ERR, "error phase left without reset")
  `CTD_ASSERT(a_data_rem, phase_q == ctd_pkg::PH_DATA |-> rem_q != '0, "data phase with no bytes remaining")
  `CTD_ASSERT(a_done_clear, step_i && done |=> !seen_q && size_q == '0 && phase_q == ctd_pkg::PH_BLANK, "chunk end did not restart header")
  `CTD_ASSERT_ALWAYS(a_hold, !step_i && rst_ni |=> $stable(phase_q) || !rst_ni, "phase moved without a transfer")

endmodule

/* rtl/core/chunked_transfer_decoder.sv */
// ---------------------------------------------------------------------------
// chunked_transfer_decoder
// Byte-serial decoder for chunked transfer framing: passes chunk payload,
// flags chunk completion and holds a sticky error on framing faults.
// ---------------------------------------------------------------------------
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid_i/in_stall_o  | in_byte_i
// out     | output    | out_valid_o/out_stall_i| payload_byte_o, payload_valid_o,
//         |           |                      | chunk_done_o, bad_request_o, phase_now_o
//
// One result per input byte; one byte per cycle sustained while the output is not stalled.
// A byte passes through the input register, then the result register; the framing
// state advances as a byte moves from one to the other.
// Reset returns to the header blank phase with cleared counters.
// A stall on the output holds the result register and then the input register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module chunked_transfer_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] payload_byte_o,
  output logic       payload_valid_o,
  output logic       chunk_done_o,
  output logic       bad_request_o,
  output logic [3:0] phase_now_o
);

  logic                 in_vld_q;
  logic [7:0]           in_byte_q;
  logic                 out_vld_q;
  ctd_pkg::result_t     res_q;
  ctd_pkg::result_t     res_d;
  ctd_pkg::byte_class_t cls;
  logic                 out_adv;
  logic                 step;

  assign out_adv    = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && out_adv;
  assign in_stall_o = in_vld_q && !out_adv;

  ctd_byte_class u_class (
    .byte_i  (in_byte_q),
    .class_o (cls)
  );

  ctd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .class_i  (cls),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (out_adv) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  // Payload registers: load on transfer, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= in_byte_i;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign payload_byte_o  = res_q.payload_byte;
  assign payload_valid_o = res_q.payload_valid;
  assign chunk_done_o    = res_q.chunk_done;
  assign bad_request_o   = res_q.bad_request;
  assign phase_now_o     = res_q.phase_now;

endmodule
